/* hdl/rks_pkg.sv */
// Package for the romaji key sequencer: payload structs, commands, result kinds,
// front-to-back queue entry and state enums. No dependencies.
`default_nettype none
package rks_pkg;
    localparam int TABLE_DEPTH_DEF = 512;
    localparam int RING_DEPTH_DEF  = 64;
    localparam int HOLD_TICKS_DEF  = 2;
    localparam logic [7:0] SHIFT_FLAG = 8'h08;
    localparam logic [7:0] LETTER_N   = 8'h4E;
    localparam logic [3:0] SHIFT_PORT = 4'd8;
    localparam logic [2:0] SHIFT_BIT  = 3'd6;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0, CMD_KEY = 2'd1, CMD_TICK = 2'd2, CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_ANSWER = 2'd0, KIND_PRESS = 2'd1, KIND_RELEASE = 2'd2, KIND_ACK = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_TABLE_ENTRIES = 2'd0, REG_N_CODES = 2'd1, REG_SMALL_TSU = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [8:0]  entry_index;
        logic [31:0] entry_letters;
        logic [2:0]  entry_length;
        logic [31:0] entry_codes;
        logic [7:0]  key;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] matrix_port;
        logic [2:0] matrix_bit;
        logic [7:0] returned_key;
        logic       last;
    } out_item_t;

    // one classified item handed from front to back
    typedef struct packed {
        cmd_t       command;
        logic       accepted;
        logic [7:0] key;
    } job_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_SCAN_RD, ST_SCAN, ST_DONE_SCAN, ST_QUEUE,
        ST_EVT_SHIFT, ST_EVT_MAIN, ST_ANSWER, ST_RING_RD, ST_TICK_EVAL
    } back_state_t;
endpackage
`default_nettype wire

/* hdl/rks_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* hdl/rks_front.sv */
// Front end: accepts input beats, upper-cases and classifies typed keys and
// pushes jobs into a two-entry queue. Depends on rks_pkg.
`default_nettype none
module rks_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire rks_pkg::in_item_t s_data,
    output logic                  q_valid,
    input  wire logic             q_pop,
    output rks_pkg::in_item_t     q_item,
    output rks_pkg::job_t         q_job
);
    rks_pkg::in_item_t item_reg [2];
    rks_pkg::job_t     job_reg [2];
    logic              rd_ptr_reg, wr_ptr_reg;
    logic [1:0]        cnt_reg;
    rks_pkg::job_t     job_c;
    logic              push;
    logic [7:0]        k;

    always_comb begin
        k = s_data.key;
        job_c.command  = rks_pkg::cmd_t'(s_data.command);
        job_c.key      = k;
        job_c.accepted = 1'b0;
        if (k == 8'h20 || k == 8'h40 || k == 8'h5B || k == 8'h2F || k == 8'h2D ||
            k == 8'h7B || k == 8'h7D || k == 8'h2E || k == 8'h2C || k == 8'h27) begin
            job_c.accepted = 1'b1;
        end else if (k >= 8'h61 && k <= 8'h7A) begin
            job_c.accepted = 1'b1;
            job_c.key      = k - 8'd32;
        end else if (k >= 8'h41 && k <= 8'h5A) begin
            job_c.accepted = 1'b1;
        end
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = item_reg[rd_ptr_reg];
    assign q_job   = job_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            item_reg[wr_ptr_reg] <= s_data;
            job_reg[wr_ptr_reg]  <= job_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule
`default_nettype wire

/* hdl/rks_back.sv */
// Back end: table scan, code ring and press timer; emits result beats through
// an output register. Depends on rks_pkg and rks_ram.
`default_nettype none
module rks_back #(
    parameter int TABLE_DEPTH = rks_pkg::TABLE_DEPTH_DEF,
    parameter int RING_DEPTH  = rks_pkg::RING_DEPTH_DEF,
    parameter int HOLD_TICKS  = rks_pkg::HOLD_TICKS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    output logic                   q_pop,
    input  wire rks_pkg::in_item_t q_item,
    input  wire rks_pkg::job_t     q_job,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [31:0]       cfg_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output rks_pkg::out_item_t     m_data
);
    localparam int TAW = $clog2(TABLE_DEPTH);
    localparam int RAW = $clog2(RING_DEPTH);
    localparam int PW  = $clog2(2 * HOLD_TICKS + 1);
    localparam logic [PW-1:0] PH_HOLD = PW'(HOLD_TICKS);
    localparam logic [PW-1:0] PH_END  = PW'(2 * HOLD_TICKS);
    localparam logic [RAW-1:0] RING_LAST = RAW'(RING_DEPTH - 1);

    rks_pkg::back_state_t state_reg, state_next;

    logic [9:0]  entries_reg;
    logic [31:0] n_codes_reg, tsu_codes_reg;
    logic [7:0]  typed_reg [4];
    logic [7:0]  typed_next [4];
    logic [2:0]  tcount_reg, tcount_next;
    logic [RAW-1:0] wr_idx_reg, wr_idx_next, rd_idx_reg, rd_idx_next;
    logic [PW-1:0]  phase_reg, phase_next;
    logic [TAW:0]   scan_reg, scan_next;
    logic           near_reg, near_next;
    logic [31:0]    qword_reg, qword_next;
    logic [2:0]     qn_reg, qn_next;
    logic [7:0]     code_reg, code_next;
    logic           rel_reg, rel_next;
    logic           out_valid_reg, out_valid_next;
    rks_pkg::out_item_t out_reg, out_next;

    logic [34:0] tl_rdata;
    logic [31:0] tc_rdata;
    logic [7:0]  ring_rdata;
    logic        t_we;
    logic [TAW-1:0] t_raddr, t_waddr;
    logic        r_we;
    logic [7:0]  r_wdata;
    logic [TAW:0] limit;
    logic        pre, exact_hit;
    logic [2:0]  ent_len;
    logic        out_free;

    assign cfg_ready = (state_reg == rks_pkg::ST_IDLE) && !q_valid;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign out_free  = !out_valid_reg || m_ready;

    assign t_waddr = TAW'(q_item.entry_index);
    assign t_we    = (state_reg == rks_pkg::ST_LOAD) && out_free &&
                     (int'(q_item.entry_index) < TABLE_DEPTH);
    assign t_raddr = scan_next[TAW-1:0];

    rks_ram #(.WIDTH(35), .DEPTH(TABLE_DEPTH)) u_letters (
        .aclk, .we(t_we), .waddr(t_waddr),
        .wdata({q_item.entry_length, q_item.entry_letters}),
        .raddr(t_raddr), .rdata(tl_rdata)
    );
    rks_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_codes (
        .aclk, .we(t_we), .waddr(t_waddr), .wdata(q_item.entry_codes),
        .raddr(t_raddr), .rdata(tc_rdata)
    );
    rks_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ring (
        .aclk, .we(r_we), .waddr(wr_idx_reg), .wdata(r_wdata),
        .raddr(rd_idx_next), .rdata(ring_rdata)
    );

    always_comb begin
        limit = (int'(entries_reg) > TABLE_DEPTH) ? (TAW+1)'(TABLE_DEPTH)
                                                   : (TAW+1)'(entries_reg);
        ent_len = tl_rdata[34:32];
        pre = (ent_len >= tcount_reg);
        for (int j = 0; j < 4; j++) begin
            if (3'(j) < tcount_reg && tl_rdata[8*j +: 8] != typed_reg[j]) pre = 1'b0;
        end
        exact_hit = pre && (ent_len == tcount_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= rks_pkg::ST_IDLE;
            entries_reg    <= '0;
            n_codes_reg    <= '0;
            tsu_codes_reg  <= '0;
            tcount_reg     <= '0;
            wr_idx_reg     <= '0;
            rd_idx_reg     <= '0;
            phase_reg      <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < 4; i++) typed_reg[i] <= '0;
        end else begin
            state_reg     <= state_next;
            tcount_reg    <= tcount_next;
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < 4; i++) typed_reg[i] <= typed_next[i];
            if (cfg_valid && cfg_ready) begin
                unique case (rks_pkg::reg_idx_t'(cfg_index))
                    rks_pkg::REG_TABLE_ENTRIES: entries_reg   <= cfg_data[9:0];
                    rks_pkg::REG_N_CODES:       n_codes_reg   <= cfg_data;
                    rks_pkg::REG_SMALL_TSU:     tsu_codes_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg       <= scan_next;
        near_reg       <= near_next;
        qword_reg      <= qword_next;
        qn_reg         <= qn_next;
        code_reg       <= code_next;
        rel_reg        <= rel_next;
        out_reg        <= out_next;
    end

    always_comb begin
        state_next      = state_reg;
        tcount_next     = tcount_reg;
        wr_idx_next     = wr_idx_reg;
        rd_idx_next     = rd_idx_reg;
        phase_next      = phase_reg;
        scan_next       = scan_reg;
        near_next       = near_reg;
        qword_next      = qword_reg;
        qn_next         = qn_reg;
        code_next       = code_reg;
        rel_next        = rel_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        q_pop           = 1'b0;
        r_we            = 1'b0;
        r_wdata         = qword_reg[7:0];
        for (int i = 0; i < 4; i++) typed_next[i] = typed_reg[i];

        unique case (state_reg)
            rks_pkg::ST_IDLE: begin
                if (q_valid) begin
                    unique case (q_job.command)
                        rks_pkg::CMD_LOAD: state_next = rks_pkg::ST_LOAD;
                        rks_pkg::CMD_KEY: begin
                            if (q_job.accepted) begin
                                typed_next[tcount_reg[1:0]] = q_job.key;
                                tcount_next = tcount_reg + 3'd1;
                                scan_next   = '0;
                                near_next   = 1'b0;
                                state_next  = rks_pkg::ST_SCAN_RD;
                            end else begin
                                state_next = rks_pkg::ST_RING_RD;
                            end
                        end
                        rks_pkg::CMD_TICK:  state_next = rks_pkg::ST_RING_RD;
                        rks_pkg::CMD_CLEAR: state_next = rks_pkg::ST_RING_RD;
                        default: ;
                    endcase
                end
            end
            rks_pkg::ST_LOAD: begin
                if (out_free) begin
                    out_next = '{kind: rks_pkg::KIND_ACK, matrix_port: '0,
                                 matrix_bit: '0, returned_key: '0, last: 1'b1};
                    out_valid_next = 1'b1;
                    q_pop = 1'b1;
                    state_next = rks_pkg::ST_IDLE;
                end
            end
            // memory read for scan_reg is in flight
            rks_pkg::ST_SCAN_RD: begin
                if (tcount_reg == 3'd0) begin
                    state_next = rks_pkg::ST_DONE_SCAN;
                end else if (scan_reg >= limit) begin
                    state_next = rks_pkg::ST_DONE_SCAN;
                end else begin
                    state_next = rks_pkg::ST_SCAN;
                end
            end
            rks_pkg::ST_SCAN: begin
                if (!pre) begin
                    if (near_reg) begin
                        state_next = rks_pkg::ST_DONE_SCAN;
                    end else begin
                        scan_next  = scan_reg + 1'b1;
                        state_next = rks_pkg::ST_SCAN_RD;
                    end
                end else if (exact_hit) begin
                    qword_next  = tc_rdata;
                    qn_next     = '0;
                    tcount_next = '0;
                    state_next  = rks_pkg::ST_QUEUE;
                end else begin
                    near_next  = 1'b1;
                    scan_next  = scan_reg + 1'b1;
                    state_next = rks_pkg::ST_SCAN_RD;
                end
            end
            rks_pkg::ST_DONE_SCAN: begin
                if (tcount_reg == 3'd0 || near_reg) begin
                    if (tcount_reg >= 3'd4) tcount_next = '0;
                    state_next = rks_pkg::ST_ANSWER;
                end else begin
                    qn_next = '0;
                    qword_next = '0;
                    if (typed_reg[0] == rks_pkg::LETTER_N) begin
                        qword_next = n_codes_reg;
                    end else if (tcount_reg >= 3'd2 && typed_reg[0] == typed_reg[1]) begin
                        qword_next = tsu_codes_reg;
                    end
                    tcount_next = tcount_reg - 3'd1;
                    typed_next[0] = typed_reg[1];
                    typed_next[1] = typed_reg[2];
                    typed_next[2] = typed_reg[3];
                    typed_next[3] = '0;
                    scan_next  = '0;
                    near_next  = 1'b0;
                    state_next = rks_pkg::ST_QUEUE;
                end
            end
            // write one code byte per cycle, then resume matching
            rks_pkg::ST_QUEUE: begin
                if (qn_reg == 3'd4 || qword_reg[7:0] == 8'd0) begin
                    scan_next  = '0;
                    near_next  = 1'b0;
                    state_next = rks_pkg::ST_SCAN_RD;
                end else begin
                    r_we        = 1'b1;
                    wr_idx_next = (wr_idx_reg == RING_LAST) ? '0 : wr_idx_reg + 1'b1;
                    qword_next  = {8'd0, qword_reg[31:8]};
                    qn_next     = qn_reg + 3'd1;
                end
            end
            rks_pkg::ST_RING_RD: begin
                code_next = '0;
                state_next = rks_pkg::ST_TICK_EVAL;
            end
            rks_pkg::ST_TICK_EVAL: begin
                code_next = ring_rdata;
                if (q_job.command == rks_pkg::CMD_TICK) begin
                    if (phase_reg == '0) begin
                        if (rd_idx_reg != wr_idx_reg) begin
                            phase_next = PW'(1);
                            rel_next   = 1'b0;
                            state_next = ring_rdata[3] ? rks_pkg::ST_EVT_SHIFT
                                                       : rks_pkg::ST_EVT_MAIN;
                        end else begin
                            state_next = rks_pkg::ST_ANSWER;
                        end
                    end else if (phase_reg == PH_HOLD) begin
                        phase_next = phase_reg + 1'b1;
                        rel_next   = 1'b1;
                        state_next = ring_rdata[3] ? rks_pkg::ST_EVT_SHIFT
                                                   : rks_pkg::ST_EVT_MAIN;
                    end else begin
                        phase_next = (phase_reg >= PH_END) ? '0 : phase_reg + 1'b1;
                        state_next = rks_pkg::ST_ANSWER;
                    end
                end else begin
                    // clear, or a rejected key: drop the held key and reset ring
                    rel_next    = 1'b1;
                    wr_idx_next = '0;
                    rd_idx_next = '0;
                    tcount_next = '0;
                    phase_next  = '0;
                    if (phase_reg != '0 && phase_reg <= PH_HOLD) begin
                        state_next = ring_rdata[3] ? rks_pkg::ST_EVT_SHIFT
                                                   : rks_pkg::ST_EVT_MAIN;
                    end else begin
                        state_next = rks_pkg::ST_ANSWER;
                    end
                end
            end
            rks_pkg::ST_EVT_SHIFT: begin
                if (out_free) begin
                    out_next = '{kind: rel_reg ? rks_pkg::KIND_RELEASE : rks_pkg::KIND_PRESS,
                                 matrix_port: rks_pkg::SHIFT_PORT,
                                 matrix_bit: rks_pkg::SHIFT_BIT,
                                 returned_key: '0, last: 1'b0};
                    out_valid_next = 1'b1;
                    state_next = rks_pkg::ST_EVT_MAIN;
                end
            end
            rks_pkg::ST_EVT_MAIN: begin
                if (out_free) begin
                    out_next = '{kind: rel_reg ? rks_pkg::KIND_RELEASE : rks_pkg::KIND_PRESS,
                                 matrix_port: code_reg[7:4], matrix_bit: code_reg[2:0],
                                 returned_key: '0, last: 1'b0};
                    out_valid_next = 1'b1;
                    if (q_job.command == rks_pkg::CMD_TICK) begin
                        out_next.last = 1'b1;
                        q_pop = 1'b1;
                        if (rel_reg) begin
                            rd_idx_next = (rd_idx_reg == RING_LAST) ? '0 : rd_idx_reg + 1'b1;
                        end
                        state_next = rks_pkg::ST_IDLE;
                    end else begin
                        state_next = rks_pkg::ST_ANSWER;
                    end
                end
            end
            rks_pkg::ST_ANSWER: begin
                if (out_free) begin
                    out_next = '{kind: rks_pkg::KIND_ANSWER, matrix_port: '0,
                                 matrix_bit: '0, returned_key: '0, last: 1'b1};
                    if (q_job.command == rks_pkg::CMD_KEY && !q_job.accepted) begin
                        out_next.returned_key = q_job.key;
                    end else if (q_job.command != rks_pkg::CMD_KEY) begin
                        out_next.kind = rks_pkg::KIND_ACK;
                    end
                    out_valid_next = 1'b1;
                    q_pop = 1'b1;
                    state_next = rks_pkg::ST_IDLE;
                end
            end
            default: state_next = rks_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* hdl/romaji_to_kana_key_sequencer.sv */
// Romaji key sequencer: typed letters are matched against a loaded table by a
// linear scan, up to four scans per key, and each command waits while an earlier
// result beat stalls. A two-deep queue lets inputs be taken while the scan runs.
// Depends on rks_pkg, rks_front, rks_back and rks_ram.
`default_nettype none
module romaji_to_kana_key_sequencer #(
    parameter int TABLE_DEPTH = rks_pkg::TABLE_DEPTH_DEF,
    parameter int RING_DEPTH  = rks_pkg::RING_DEPTH_DEF,
    parameter int HOLD_TICKS  = rks_pkg::HOLD_TICKS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire rks_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output rks_pkg::out_item_t      m_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);
    logic              q_valid, q_pop;
    rks_pkg::in_item_t q_item;
    rks_pkg::job_t     q_job;

    rks_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .q_valid, .q_pop, .q_item, .q_job
    );

    rks_back #(
        .TABLE_DEPTH(TABLE_DEPTH), .RING_DEPTH(RING_DEPTH), .HOLD_TICKS(HOLD_TICKS)
    ) u_back (
        .aclk, .aresetn, .q_valid, .q_pop, .q_item, .q_job,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .m_valid, .m_ready, .m_data
    );
endmodule
`default_nettype wire
